// ===== sv/sc1af_pkg.sv =====
// ============================================================================
// sc1af_pkg
// Shared types, constants and translation tables for the set-1 scan code
// to ASCII translator with character buffer.
// ============================================================================
`default_nettype none

package sc1af_pkg;

    // Character buffer geometry
    localparam int BUF_DEPTH = 256;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int CHAR_W    = 7;
    localparam int FILL_W    = 8;

    // Op queue between classifier and executor
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 2 ** QPTR_W;

    // Stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Scan code values
    localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
    localparam logic [6:0] SC_LSHIFT     = 7'h2A;
    localparam logic [6:0] SC_RSHIFT     = 7'h36;
    localparam logic [6:0] SC_CTRL       = 7'h1D;
    localparam logic [6:0] SC_KEY_C      = 7'h2E;
    localparam logic [6:0] SC_KEY_Z      = 7'h2C;
    localparam logic [6:0] SC_UP         = 7'h48;
    localparam logic [6:0] SC_DOWN       = 7'h50;
    localparam logic [6:0] SC_RIGHT      = 7'h4D;
    localparam logic [6:0] SC_LEFT       = 7'h4B;

    // Characters of the cursor escape sequence
    localparam logic [CHAR_W-1:0] CH_ESC     = 7'h1B;
    localparam logic [CHAR_W-1:0] CH_BRACKET = 7'h5B;
    localparam logic [CHAR_W-1:0] CH_A       = 7'h41;
    localparam logic [CHAR_W-1:0] CH_B       = 7'h42;
    localparam logic [CHAR_W-1:0] CH_C       = 7'h43;
    localparam logic [CHAR_W-1:0] CH_D       = 7'h44;

    // Request kinds on the input tuser
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_INT  = 2'd1,
        SIG_STOP = 2'd2
    } t_sig;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SIG,
        OP_PUSH,
        OP_ARROW,
        OP_READ
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        logic [CHAR_W-1:0]   chr;
        t_sig                sig;
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARROW2,
        S_ARROW3,
        S_READ
    } t_back_state;

    // Translation tables, indexed by scan code
    localparam int TABLE_LEN = 84;

    localparam logic [CHAR_W-1:0] PLAIN_MAP [TABLE_LEN] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
        7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
        7'h32, 7'h33, 7'h30, 7'h2E
    };

    localparam logic [CHAR_W-1:0] SHIFTED_MAP [TABLE_LEN] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
        7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
        7'h32, 7'h33, 7'h30, 7'h2E
    };

endpackage

`default_nettype wire

// ===== sv/sc1af_ram.sv =====
// ============================================================================
// sc1af_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module sc1af_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/sc1af_front.sv =====
// ============================================================================
// sc1af_front
// Input side: accepts scan code beats and read requests, tracks the shift,
// ctrl and extended-prefix flags, and turns each beat into one op.
// ============================================================================
`default_nettype none

module sc1af_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_req_type,
    input  wire logic [7:0]      i_scan_code,
    input  wire logic            i_queue_full,
    output logic                 o_ready,
    output logic                 o_push,
    output sc1af_pkg::t_op       o_op
);

    logic r_shift;
    logic r_ctrl;
    logic r_ext;
    logic n_shift;
    logic n_ctrl;
    logic n_ext;

    logic                          accept;
    logic [6:0]                    key;
    logic [sc1af_pkg::CHAR_W-1:0]  map_chr;
    logic [sc1af_pkg::CHAR_W-1:0]  fin;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;
    assign key     = i_scan_code[6:0];

    // Table lookup for plain presses
    assign map_chr = r_shift ? sc1af_pkg::SHIFTED_MAP[key] : sc1af_pkg::PLAIN_MAP[key];

    // Final character of the cursor sequence
    always_comb begin
        priority if (key == sc1af_pkg::SC_UP) begin
            fin = sc1af_pkg::CH_A;
        end else if (key == sc1af_pkg::SC_DOWN) begin
            fin = sc1af_pkg::CH_B;
        end else if (key == sc1af_pkg::SC_RIGHT) begin
            fin = sc1af_pkg::CH_C;
        end else if (key == sc1af_pkg::SC_LEFT) begin
            fin = sc1af_pkg::CH_D;
        end else begin
            fin = '0;
        end
    end

    // Classify the beat and work out the next modifier flags
    always_comb begin
        n_shift     = r_shift;
        n_ctrl      = r_ctrl;
        n_ext       = r_ext;
        o_op.kind   = sc1af_pkg::OP_NONE;
        o_op.chr    = '0;
        o_op.sig    = sc1af_pkg::SIG_NONE;
        if (i_req_type == sc1af_pkg::REQ_READ) begin
            o_op.kind = sc1af_pkg::OP_READ;
        end else begin
            priority if (i_scan_code == sc1af_pkg::SC_EXT_PREFIX) begin
                n_ext = 1'b1;
            end else if (i_scan_code[7]) begin
                if (key == sc1af_pkg::SC_LSHIFT || key == sc1af_pkg::SC_RSHIFT) begin
                    n_shift = 1'b0;
                end
                if (key == sc1af_pkg::SC_CTRL) begin
                    n_ctrl = 1'b0;
                end
                n_ext = 1'b0;
            end else if (key == sc1af_pkg::SC_LSHIFT || key == sc1af_pkg::SC_RSHIFT) begin
                n_shift = 1'b1;
                n_ext   = 1'b0;
            end else if (key == sc1af_pkg::SC_CTRL) begin
                n_ctrl = 1'b1;
                n_ext  = 1'b0;
            end else if (r_ext) begin
                n_ext = 1'b0;
                if (fin != '0) begin
                    o_op.kind = sc1af_pkg::OP_ARROW;
                    o_op.chr  = fin;
                end
            end else if (key >= 7'(sc1af_pkg::TABLE_LEN)) begin
                o_op.kind = sc1af_pkg::OP_NONE;
            end else if (r_ctrl && key == sc1af_pkg::SC_KEY_C) begin
                o_op.kind = sc1af_pkg::OP_SIG;
                o_op.sig  = sc1af_pkg::SIG_INT;
            end else if (r_ctrl && key == sc1af_pkg::SC_KEY_Z) begin
                o_op.kind = sc1af_pkg::OP_SIG;
                o_op.sig  = sc1af_pkg::SIG_STOP;
            end else if (map_chr != '0) begin
                o_op.kind = sc1af_pkg::OP_PUSH;
                o_op.chr  = map_chr;
            end else begin
                o_op.kind = sc1af_pkg::OP_NONE;
            end
        end
    end

    // Update flags on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_ctrl  <= 1'b0;
            r_ext   <= 1'b0;
        end else if (accept) begin
            r_shift <= n_shift;
            r_ctrl  <= n_ctrl;
            r_ext   <= n_ext;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sc1af_queue.sv =====
// ============================================================================
// sc1af_queue
// Short op queue that decouples the classifier from the buffer executor.
// ============================================================================
`default_nettype none

module sc1af_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sc1af_pkg::t_op  i_op,
    output logic                 o_full,
    input  wire logic            i_pop,
    output sc1af_pkg::t_op       o_op,
    output logic                 o_valid
);

    sc1af_pkg::t_op                r_mem [sc1af_pkg::QUEUE_DEPTH];
    logic [sc1af_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [sc1af_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [sc1af_pkg::QPTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (sc1af_pkg::QPTR_W+1)'(sc1af_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd_ptr];

    // Store pushed ops
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/sc1af_back.sv =====
// ============================================================================
// sc1af_back
// Executor: carries out queued ops on the character ring buffer and drives
// the result register.
// ============================================================================
`default_nettype none

module sc1af_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sc1af_pkg::t_op                i_op,
    input  wire logic                          i_op_valid,
    output logic                               o_op_pop,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic [sc1af_pkg::CHAR_W-1:0]       o_read_char,
    output logic                               o_read_valid,
    output logic [1:0]                         o_signal_raise,
    output logic [sc1af_pkg::FILL_W-1:0]       o_fill_level
);

    localparam logic [sc1af_pkg::PTR_W-1:0] LAST_PTR =
        sc1af_pkg::PTR_W'(sc1af_pkg::BUF_DEPTH - 1);

    sc1af_pkg::t_back_state        r_state;
    sc1af_pkg::t_back_state        n_state;
    logic [sc1af_pkg::PTR_W-1:0]   r_wr_ptr;
    logic [sc1af_pkg::PTR_W-1:0]   n_wr_ptr;
    logic [sc1af_pkg::PTR_W-1:0]   r_rd_ptr;
    logic [sc1af_pkg::PTR_W-1:0]   n_rd_ptr;
    logic [sc1af_pkg::PTR_W-1:0]   r_count;
    logic [sc1af_pkg::PTR_W-1:0]   n_count;
    logic [sc1af_pkg::CHAR_W-1:0]  r_fin;

    logic                          r_out_valid;
    logic [sc1af_pkg::CHAR_W-1:0]  r_out_char;
    logic                          r_out_flag;
    logic [1:0]                    r_out_sig;
    logic [sc1af_pkg::FILL_W-1:0]  r_out_fill;

    logic                          slot_free;
    logic                          full;
    logic                          push_req;
    logic [sc1af_pkg::CHAR_W-1:0]  push_chr;
    logic                          rd_req;
    logic                          emit;
    logic [sc1af_pkg::CHAR_W-1:0]  res_chr;
    logic                          res_flag;
    logic [1:0]                    res_sig;
    logic                          ram_we;
    logic [sc1af_pkg::CHAR_W-1:0]  ram_rdata;
    logic [sc1af_pkg::PTR_W+sc1af_pkg::FILL_W-1:0] cnt_ext;

    assign slot_free = !r_out_valid || i_res_ready;
    assign full      = (r_count == LAST_PTR);

    // Sequence each op; at most one buffer write per cycle
    always_comb begin
        n_state  = r_state;
        o_op_pop = 1'b0;
        push_req = 1'b0;
        push_chr = i_op.chr;
        rd_req   = 1'b0;
        emit     = 1'b0;
        res_chr  = '0;
        res_flag = 1'b0;
        res_sig  = sc1af_pkg::SIG_NONE;
        unique case (r_state)
            sc1af_pkg::S_IDLE: begin
                if (i_op_valid) begin
                    unique case (i_op.kind)
                        sc1af_pkg::OP_ARROW: begin
                            o_op_pop = 1'b1;
                            push_req = 1'b1;
                            push_chr = sc1af_pkg::CH_ESC;
                            n_state  = sc1af_pkg::S_ARROW2;
                        end
                        sc1af_pkg::OP_READ: begin
                            if (r_count != '0) begin
                                o_op_pop = 1'b1;
                                rd_req   = 1'b1;
                                n_state  = sc1af_pkg::S_READ;
                            end else if (slot_free) begin
                                o_op_pop = 1'b1;
                                emit     = 1'b1;
                            end
                        end
                        sc1af_pkg::OP_PUSH: begin
                            if (slot_free) begin
                                o_op_pop = 1'b1;
                                push_req = 1'b1;
                                emit     = 1'b1;
                            end
                        end
                        sc1af_pkg::OP_SIG: begin
                            if (slot_free) begin
                                o_op_pop = 1'b1;
                                emit     = 1'b1;
                                res_sig  = i_op.sig;
                            end
                        end
                        default: begin
                            if (slot_free) begin
                                o_op_pop = 1'b1;
                                emit     = 1'b1;
                            end
                        end
                    endcase
                end
            end
            sc1af_pkg::S_ARROW2: begin
                push_req = 1'b1;
                push_chr = sc1af_pkg::CH_BRACKET;
                n_state  = sc1af_pkg::S_ARROW3;
            end
            sc1af_pkg::S_ARROW3: begin
                if (slot_free) begin
                    push_req = 1'b1;
                    push_chr = r_fin;
                    emit     = 1'b1;
                    n_state  = sc1af_pkg::S_IDLE;
                end
            end
            sc1af_pkg::S_READ: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    res_chr  = ram_rdata;
                    res_flag = 1'b1;
                    n_state  = sc1af_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sc1af_pkg::S_IDLE;
            end
        endcase
    end

    // Apply buffer writes and reads to pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        ram_we   = push_req && !full;
        if (ram_we) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (rd_req) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    assign cnt_ext = {{sc1af_pkg::FILL_W{1'b0}}, n_count};

    sc1af_ram #(
        .WIDTH (sc1af_pkg::CHAR_W),
        .DEPTH (sc1af_pkg::BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (push_chr),
        .i_re    (rd_req),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sc1af_pkg::S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the arrow final character and the result payload
    always_ff @(posedge i_clk) begin
        if (r_state == sc1af_pkg::S_IDLE && o_op_pop) begin
            r_fin <= i_op.chr;
        end
        if (emit) begin
            r_out_char <= res_chr;
            r_out_flag <= res_flag;
            r_out_sig  <= res_sig;
            r_out_fill <= cnt_ext[sc1af_pkg::FILL_W-1:0];
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_read_char    = r_out_char;
    assign o_read_valid   = r_out_flag;
    assign o_signal_raise = r_out_sig;
    assign o_fill_level   = r_out_fill;

endmodule

`default_nettype wire

// ===== sv/scancode_set1_ascii_fifo.sv =====
// ============================================================================
// scancode_set1_ascii_fifo
// Set-1 scan code to ASCII translator with a character ring buffer.
//
//   Channel  Dir  tdata (low bit up)                      tuser
//   s_axis   in   scan_code[7:0]                          req_type
//   m_axis   out  read_char[6:0] signal_raise[8:7]        read_valid
//                 fill_level[16:9], zero pad [23:17]
//
// One result beat per input beat. Plain keys, modifiers, signals, ignored
// codes and empty reads end in S_IDLE; a read that finds a character also
// passes S_READ (registered RAM read); a cursor key passes S_ARROW2 and
// S_ARROW3 (one RAM write port, three characters). A 2-entry op queue lets
// input beats enter while the executor or stalled result register is busy.
// Synchronous reset clears flags, pointers and handshake state; buffer
// contents are not cleared and are never read before being written.
// ============================================================================
`default_nettype none

module scancode_set1_ascii_fifo (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [sc1af_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // scan_code
    input  wire logic                              s_axis_tuser,  // req_type
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // read_char, signal_raise, fill_level, zero pad
    output logic [sc1af_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tuser   // read_valid
);

    sc1af_pkg::t_op                front_op;
    sc1af_pkg::t_op                queue_op;
    logic                          front_push;
    logic                          queue_full;
    logic                          queue_valid;
    logic                          queue_pop;
    logic [sc1af_pkg::CHAR_W-1:0]  read_char;
    logic [1:0]                    signal_raise;
    logic [sc1af_pkg::FILL_W-1:0]  fill_level;

    // Classify each input beat
    sc1af_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_req_type   (s_axis_tuser),
        .i_scan_code  (s_axis_tdata),
        .i_queue_full (queue_full),
        .o_ready      (s_axis_tready),
        .o_push       (front_push),
        .o_op         (front_op)
    );

    // Decouple classifier from executor
    sc1af_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_op    (front_op),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_op    (queue_op),
        .o_valid (queue_valid)
    );

    // Execute ops against the buffer
    sc1af_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (queue_op),
        .i_op_valid     (queue_valid),
        .o_op_pop       (queue_pop),
        .o_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .o_read_char    (read_char),
        .o_read_valid   (m_axis_tuser),
        .o_signal_raise (signal_raise),
        .o_fill_level   (fill_level)
    );

    // Pack the result beat
    assign m_axis_tdata = {7'b0, fill_level, signal_raise, read_char};

endmodule

`default_nettype wire

// ===== sv/sc1af_checker.sv =====
// ============================================================================
// sc1af_checker
// Port-level checks on the translator's result stream.
// ============================================================================
`default_nettype none

module sc1af_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [sc1af_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                              m_axis_tuser
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // A successful read never raises a signal
    a_read_no_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[8:7] == 2'd0)
        else $error("signal raised on a read beat");

    // No character without read_valid
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[6:0] == 7'd0)
        else $error("character shown without read_valid");

    // Signal code stays in range and pad bits stay clear
    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[8:7] != 2'd3 && m_axis_tdata[23:17] == 7'd0)
        else $error("bad signal code or pad bits");

endmodule

bind scancode_set1_ascii_fifo sc1af_checker u_checker (.*);

`default_nettype wire
